### hw/rtl/peak_compressor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the peak compressor
// Implication checks on the block clock, disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef PEAK_COMPRESSOR_ASSERT_SVH
`define PEAK_COMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PKC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("peak compressor check failed");
`define PKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("peak compressor check failed");
`else
`define PKC_ASSERT_IMP(label, ante, cons)
`define PKC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/pkc_pkg.sv
// ---------------------------------------------------------------------------
// Peak compressor package
// Shared widths, register indexes and the serial multiplier request type.
// ---------------------------------------------------------------------------
package pkc_pkg;

  // Accumulator width of the shift-add multiplier.
  localparam int ACC_W = 68;
  localparam int MPL_W = 24;
  localparam int CNT_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd6;

  // One multiply job: acc = init + mcand * mplier, over nbits multiplier bits.
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] init;
    logic signed [ACC_W-1:0] mcand;
    logic [MPL_W-1:0]        mplier;
    logic [CNT_W-1:0]        nbits;
  } mul_req_t;

endpackage

### hw/rtl/pkc_sample_if.sv
// ---------------------------------------------------------------------------
// Peak compressor input channel
// Valid/ready channel carrying one frame of two samples per word.
// ---------------------------------------------------------------------------
interface pkc_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_zero;
  logic signed [SAMPLE_BITS-1:0] sample_one;

  modport source (output valid, output sample_zero, output sample_one, input ready);
  modport sink (input valid, input sample_zero, input sample_one, output ready);
endinterface

### hw/rtl/pkc_result_if.sv
// ---------------------------------------------------------------------------
// Peak compressor result channel
// Valid/ready channel carrying compressed samples and the current gain.
// ---------------------------------------------------------------------------
interface pkc_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_zero;
  logic signed [SAMPLE_BITS-1:0] out_one;
  logic [16:0]                   gain_now;

  modport source (output valid, output out_zero, output out_one, output gain_now,
                  input ready);
  modport sink (input valid, input out_zero, input out_one, input gain_now,
                output ready);
endinterface

### hw/rtl/pkc_serial_mul.sv
// ---------------------------------------------------------------------------
// Peak compressor serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, with a preset accumulator.
// ---------------------------------------------------------------------------
module pkc_serial_mul import pkc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_req_t                req_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [MPL_W-1:0]        mplier_q, mplier_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;

  // One step per cycle: add the shifted multiplicand when the low bit is set.
  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      acc_d    = req_i.init;
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      cnt_d    = req_i.nbits;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

### hw/rtl/peak_compressor.sv
// ---------------------------------------------------------------------------
// Peak compressor
// Feedforward peak compressor with release, attack and knee smoothers.
// ---------------------------------------------------------------------------
// A frame arrives on smp_i as one word (two samples); the result word on res_o
// carries both compressed samples and the smoothed gain after that frame.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i; the user
// writes them only while no frame is in flight; the block does not enforce it.
// One frame at a time is processed. All multiplies run on one shift-add unit
// that retires a multiplier bit per cycle, and the gain division retires one
// quotient bit per cycle. The multiplier and divider steps set how long a
// frame takes; the division is skipped when the target is known without it.
// The result is held in an output register, so the next frame is accepted
// while a result still waits. If the receiver stalls, the finished frame waits
// until the output register is free.
// Reset clears the smoother state to zero and loads the default registers.
// ---------------------------------------------------------------------------
module peak_compressor import pkc_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pkc_sample_if.sink            smp_i,
  pkc_result_if.source          res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SB       = SAMPLE_BITS;
  localparam int DET_UP   = (SB < 17) ? 17 - SB : 0;
  localparam int DET_DOWN = (SB > 17) ? SB - 17 : 0;
  localparam int RES_W    = ACC_W - 30;
  localparam logic [RES_W-1:0] LIM_POS = (RES_W'(1) << (SB - 1)) - RES_W'(1);
  localparam logic [RES_W-1:0] LIM_NEG = RES_W'(1) << (SB - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REL  = 4'd1;
  localparam logic [3:0] S_ATT  = 4'd2;
  localparam logic [3:0] S_NUM  = 4'd3;
  localparam logic [3:0] S_DCHK = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DFIN = 4'd6;
  localparam logic [3:0] S_KNEE = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // Configuration registers.
  logic [16:0] thr_q, rat_q;
  logic [15:0] atk_q, rls_q, knee_q;
  logic [23:0] mkp_q;
  logic [1:0]  chn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ONE_Q16;
      rat_q  <= ONE_Q16;
      atk_q  <= '0;
      rls_q  <= '0;
      knee_q <= '0;
      mkp_q  <= 24'd16384;
      chn_q  <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_THRESHOLD: thr_q  <= cfg_data_i[16:0];
        REG_RATIO:     rat_q  <= cfg_data_i[16:0];
        REG_ATTACK:    atk_q  <= cfg_data_i[15:0];
        REG_RELEASE:   rls_q  <= cfg_data_i[15:0];
        REG_KNEE:      knee_q <= cfg_data_i[15:0];
        REG_MAKEUP:    mkp_q  <= cfg_data_i;
        REG_CHANNELS:  chn_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Register state.
  logic [3:0]           state_q, state_d;
  logic                 launched_q, launched_d;
  logic                 two_q, two_d;
  logic                 ch_q, ch_d;
  logic signed [SB-1:0] x0_q, x0_d, x1_q, x1_d;
  logic [17:0]          det_q, det_d;
  logic [17:0]          rel_q, rel_d, att_q, att_d;
  logic [16:0]          gain_q, gain_d, tgt_q, tgt_d;
  logic [35:0]          rem_q, rem_d, dvs_q, dvs_d;
  logic [16:0]          quo_q, quo_d;
  logic [4:0]           bit_q, bit_d;
  logic [ACC_W-1:0]     p1_q, p1_d;
  logic signed [SB-1:0] o0_q, o0_d, o1_q, o1_d;
  logic                 ovalid_q, ovalid_d;
  logic signed [SB-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [16:0]          rg_q, rg_d;

  mul_req_t                mreq;
  logic signed [ACC_W-1:0] macc;
  logic                    mdone;

  pkc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .acc_o  (macc),
    .done_o (mdone)
  );

  // Detector on the incoming frame.
  logic            two_in;
  logic signed [SB:0] sum_in;
  logic [SB:0]     mag_in;
  logic [SB+DET_UP:0] det_wide;
  logic [16:0]     thr_c, rat_c;

  always_comb begin
    two_in   = (CHANNELS >= 2) && (chn_q >= 2'd2);
    sum_in   = (SB+1)'(smp_i.sample_zero) +
               (two_in ? (SB+1)'(smp_i.sample_one) : '0);
    mag_in   = sum_in[SB] ? (SB+1)'(-sum_in) : (SB+1)'(sum_in);
    det_wide = (SB+DET_UP+1)'(mag_in) << DET_UP;
    thr_c    = (thr_q > ONE_Q16) ? ONE_Q16 : thr_q;
    rat_c    = (rat_q > ONE_Q16) ? ONE_Q16 : rat_q;
  end

  // Per-channel magnitude and output rounding.
  logic signed [SB-1:0] xc;
  logic                 negc;
  logic signed [SB:0]   xce;
  logic [SB-1:0]        magc;
  logic [17:0]          held;
  logic [RES_W-1:0]     rmag, rlim, rsat;
  logic signed [SB-1:0] rout;

  always_comb begin
    xc   = ch_q ? x1_q : x0_q;
    negc = xc[SB-1];
    xce  = (SB+1)'(xc);
    magc = negc ? SB'(-xce) : SB'(xce);
    held = (det_q > rel_q) ? det_q : rel_q;
    rmag = macc[ACC_W-1:30];
    rlim = negc ? LIM_NEG : LIM_POS;
    rsat = (rmag > rlim) ? rlim : rmag;
    rout = negc ? SB'(-rsat) : SB'(rsat);
  end

  // Multiplier operands for each step.
  always_comb begin
    mreq        = '0;
    mreq.start  = (!launched_q) && (state_q == S_REL || state_q == S_ATT ||
                  state_q == S_NUM || state_q == S_KNEE || state_q == S_P1 ||
                  state_q == S_P2);
    unique case (state_q)
      S_REL: begin
        mreq.init   = ACC_W'({det_q, 16'h8000});
        mreq.mcand  = ACC_W'(held) - ACC_W'(det_q);
        mreq.mplier = MPL_W'(rls_q);
        mreq.nbits  = CNT_W'(16);
      end
      S_ATT: begin
        mreq.init   = ACC_W'({rel_q, 16'h8000});
        mreq.mcand  = ACC_W'(att_q) - ACC_W'(rel_q);
        mreq.mplier = MPL_W'(atk_q);
        mreq.nbits  = CNT_W'(16);
      end
      S_NUM: begin
        mreq.init   = ACC_W'({thr_c, 16'h0000});
        mreq.mcand  = ACC_W'(att_q) - ACC_W'(thr_c);
        mreq.mplier = MPL_W'(rat_c);
        mreq.nbits  = CNT_W'(17);
      end
      S_KNEE: begin
        mreq.init   = ACC_W'({tgt_q, 16'h8000});
        mreq.mcand  = ACC_W'(gain_q) - ACC_W'(tgt_q);
        mreq.mplier = MPL_W'(knee_q);
        mreq.nbits  = CNT_W'(16);
      end
      S_P1: begin
        mreq.init   = '0;
        mreq.mcand  = ACC_W'(magc);
        mreq.mplier = MPL_W'(gain_q);
        mreq.nbits  = CNT_W'(17);
      end
      S_P2: begin
        mreq.init   = ACC_W'(1) <<< 29;
        mreq.mcand  = p1_q;
        mreq.mplier = mkp_q;
        mreq.nbits  = CNT_W'(24);
      end
      default: ;
    endcase
  end

  // Frame sequencer.
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    two_d      = two_q;
    ch_d       = ch_q;
    x0_d       = x0_q;
    x1_d       = x1_q;
    det_d      = det_q;
    rel_d      = rel_q;
    att_d      = att_q;
    gain_d     = gain_q;
    tgt_d      = tgt_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    quo_d      = quo_q;
    bit_d      = bit_q;
    p1_d       = p1_q;
    o0_d       = o0_q;
    o1_d       = o1_q;
    r0_d       = r0_q;
    r1_d       = r1_q;
    rg_d       = rg_q;
    ovalid_d   = ovalid_q && !res_o.ready;

    if (mreq.start) begin
      launched_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (smp_i.valid) begin
          x0_d    = smp_i.sample_zero;
          x1_d    = smp_i.sample_one;
          two_d   = two_in;
          det_d   = 18'(det_wide >> DET_DOWN);
          ch_d    = 1'b0;
          state_d = S_REL;
        end
      end
      S_REL: begin
        if (mdone) begin
          launched_d = 1'b0;
          rel_d      = macc[33:16];
          state_d    = S_ATT;
        end
      end
      S_ATT: begin
        if (mdone) begin
          launched_d = 1'b0;
          att_d      = macc[33:16];
          state_d    = S_NUM;
        end
      end
      S_NUM: begin
        if (mdone) begin
          launched_d = 1'b0;
          rem_d      = macc[35:0];
          if (att_q == 18'd0) begin
            tgt_d   = ONE_Q16;
            state_d = S_KNEE;
          end else if (macc[ACC_W-1] || macc == '0) begin
            tgt_d   = '0;
            state_d = S_KNEE;
          end else begin
            state_d = S_DCHK;
          end
        end
      end
      S_DCHK: begin
        // A quotient of two or more clamps without dividing.
        if (rem_q >= 36'({att_q, 17'h0})) begin
          tgt_d   = ONE_Q16;
          state_d = S_KNEE;
        end else begin
          dvs_d   = 36'({att_q, 16'h0});
          quo_d   = '0;
          bit_d   = 5'd16;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_q >= dvs_q) begin
          rem_d = rem_q - dvs_q;
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          quo_d = {quo_q[15:0], 1'b0};
        end
        dvs_d = dvs_q >> 1;
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        tgt_d   = (quo_q > ONE_Q16) ? ONE_Q16 : quo_q;
        state_d = S_KNEE;
      end
      S_KNEE: begin
        if (mdone) begin
          launched_d = 1'b0;
          gain_d     = macc[32:16];
          state_d    = S_P1;
        end
      end
      S_P1: begin
        if (mdone) begin
          launched_d = 1'b0;
          p1_d       = macc;
          state_d    = S_P2;
        end
      end
      S_P2: begin
        if (mdone) begin
          launched_d = 1'b0;
          if (ch_q) begin
            o1_d = rout;
          end else begin
            o0_d = rout;
          end
          if (!ch_q && two_q) begin
            ch_d    = 1'b1;
            state_d = S_P1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        // Load the output register once the previous word has left.
        if (!ovalid_q || res_o.ready) begin
          r0_d     = o0_q;
          r1_d     = two_q ? o1_q : '0;
          rg_d     = gain_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
      ovalid_q   <= 1'b0;
      rel_q      <= '0;
      att_q      <= '0;
      gain_q     <= '0;
      ch_q       <= 1'b0;
      two_q      <= 1'b0;
      bit_q      <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      ovalid_q   <= ovalid_d;
      rel_q      <= rel_d;
      att_q      <= att_d;
      gain_q     <= gain_d;
      ch_q       <= ch_d;
      two_q      <= two_d;
      bit_q      <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q  <= x0_d;
    x1_q  <= x1_d;
    det_q <= det_d;
    tgt_q <= tgt_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    p1_q  <= p1_d;
    o0_q  <= o0_d;
    o1_q  <= o1_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    rg_q  <= rg_d;
  end

  assign smp_i.ready    = (state_q == S_IDLE);
  assign res_o.valid    = ovalid_q;
  assign res_o.out_zero = r0_q;
  assign res_o.out_one  = r1_q;
  assign res_o.gain_now = rg_q;

  // Checks on the sequencer and the gain state.
`include "peak_compressor_assert.svh"
  `PKC_ASSERT_NEXT(a_accept_busy, smp_i.valid && smp_i.ready, state_q != S_IDLE)
  `PKC_ASSERT_IMP(a_done_launched, mdone, launched_q)
  `PKC_ASSERT_IMP(a_gain_range, 1'b1, gain_q <= ONE_Q16)

endmodule

### sim/tb_peak_compressor.sv
// ---------------------------------------------------------------------------
// Peak compressor testbench
// Drives sample frames through the valid/ready channel with random gaps and
// checks every result word against a cycle-free predictor of the compressor.
// ---------------------------------------------------------------------------
module tb_peak_compressor import pkc_pkg::*; ();

  // A sample frame as it is driven and a result word as it is expected.
  typedef struct packed {
    logic signed [15:0] s0;
    logic signed [15:0] s1;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] o0;
    logic signed [15:0] o1;
    logic [16:0]        gain;
  } result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pkc_sample_if #(.SAMPLE_BITS(16)) smp_if ();
  pkc_result_if #(.SAMPLE_BITS(16)) res_if ();

  peak_compressor #(.CHANNELS(2), .SAMPLE_BITS(16)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_if.sink),
    .res_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the registers and smoother state.
  logic [16:0] thr_reg, ratio_reg;
  logic [15:0] att_coef, rel_coef, knee_reg;
  logic [23:0] makeup_reg;
  logic [1:0]  chan_reg;
  logic [17:0] rel_env, att_env;
  logic [16:0] gain_st;

  frame_t  frame_q[$];
  result_t expect_q[$];
  int      mismatches;
  int      words_seen;
  int      frames_sent;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #12000000;
    $display("peak_compressor verification failed");
    $finish;
  end

  function automatic logic [31:0] smooth(input logic [15:0] coef, input longint fresh,
                                         input longint held);
    longint acc;
    acc = (65536 - longint'(coef)) * fresh + longint'(coef) * held + 32768;
    return 32'(acc >>> 16);
  endfunction

  function automatic logic [15:0] scale_sample(input longint x, input logic [16:0] g);
    longint mag, lim, r;
    mag = (x < 0) ? -x : x;
    lim = (x < 0) ? 32768 : 32767;
    r = (mag * longint'(g) * longint'(makeup_reg) + (longint'(1) << 29)) >>> 30;
    if (r > lim) r = lim;
    if (x < 0) r = -r;
    return r[15:0];
  endfunction

  // Work out the result word of one frame and advance the smoother state.
  function automatic result_t compress_frame(input frame_t f);
    result_t r;
    int      n;
    longint  x0, x1, sum, det, held, thr, rat, num, tgt;
    n = (chan_reg == 2'd0) ? 1 : (chan_reg > 2'd2 ? 2 : int'(chan_reg));
    x0 = longint'(f.s0);
    x1 = longint'(f.s1);
    sum = x0 + ((n == 2) ? x1 : 0);
    det = ((sum < 0) ? -sum : sum) << 1;
    held = (det > longint'(rel_env)) ? det : longint'(rel_env);
    rel_env = 18'(smooth(rel_coef, det, held));
    att_env = 18'(smooth(att_coef, longint'(rel_env), longint'(att_env)));
    thr = (thr_reg > 17'h10000) ? 65536 : longint'(thr_reg);
    rat = (ratio_reg > 17'h10000) ? 65536 : longint'(ratio_reg);
    if (att_env == 0) begin
      tgt = 65536;
    end else begin
      num = thr * 65536 + rat * (longint'(att_env) - thr);
      if (num <= 0) begin
        tgt = 0;
      end else begin
        tgt = num / longint'(att_env);
        if (tgt > 65536) tgt = 65536;
      end
    end
    gain_st = 17'(smooth(knee_reg, tgt, longint'(gain_st)));
    r.o0 = scale_sample(x0, gain_st);
    r.o1 = (n == 2) ? scale_sample(x1, gain_st) : 16'sd0;
    r.gain = gain_st;
    return r;
  endfunction

  // Driver: one frame from the queue after a random gap.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid       <= 1'b0;
      smp_if.sample_zero <= '0;
      smp_if.sample_one  <= '0;
      gap_left           <= 0;
    end else if (smp_if.valid && !smp_if.ready) begin
      // Hold the word until it is taken.
    end else if (gap_left > 0) begin
      smp_if.valid <= 1'b0;
      gap_left     <= gap_left - 1;
    end else if (frame_q.size() > 0) begin
      frame_t f;
      f = frame_q.pop_front();
      expect_q.push_back(compress_frame(f));
      smp_if.valid       <= 1'b1;
      smp_if.sample_zero <= f.s0;
      smp_if.sample_one  <= f.s1;
      frames_sent        <= frames_sent + 1;
      gap_left           <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    end else begin
      smp_if.valid <= 1'b0;
    end
  end

  // Monitor: random receive stalls, compare each word with the oldest expectation.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        result_t want;
        words_seen <= words_seen + 1;
        if (expect_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word: %p",
            {res_if.out_zero, res_if.out_one, res_if.gain_now});
        end else begin
          want = expect_q.pop_front();
          if (want.o0 !== res_if.out_zero || want.o1 !== res_if.out_one ||
              want.gain !== res_if.gain_now) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %0d %0d gain %0d, got %0d %0d gain %0d",
                       want.o0, want.o1, want.gain,
                       res_if.out_zero, res_if.out_one, res_if.gain_now);
          end
        end
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg    = val[16:0];
      REG_RATIO:     ratio_reg  = val[16:0];
      REG_ATTACK:    att_coef   = val[15:0];
      REG_RELEASE:   rel_coef   = val[15:0];
      REG_KNEE:      knee_reg   = val[15:0];
      REG_MAKEUP:    makeup_reg = val;
      REG_CHANNELS:  chan_reg   = val[1:0];
      default: ;
    endcase
  endtask

  // Wait until every frame has been answered, then let the block settle.
  task automatic drain();
    while (frame_q.size() > 0 || expect_q.size() > 0 || smp_if.valid) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic frame_t rand_frame();
    frame_t f;
    int     kind;
    kind = $urandom_range(0, 9);
    f.s0 = 16'($urandom);
    f.s1 = 16'($urandom);
    // Mostly full-range noise, with quiet passages and near full scale bursts.
    if (kind < 2) begin
      f.s0 = 16'($signed($urandom_range(0, 200)) - 100);
      f.s1 = 16'($signed($urandom_range(0, 200)) - 100);
    end else if (kind == 2) begin
      f.s0 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      f.s1 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return f;
  endfunction

  task automatic push_random(input int count);
    repeat (count) frame_q.push_back(rand_frame());
  endtask

  // Stimulus and configuration phases.
  initial begin
    frame_t f;
    mismatches = 0;
    words_seen = 0;
    frames_sent = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    thr_reg = 17'h10000; ratio_reg = 17'h10000;
    att_coef = '0; rel_coef = '0; knee_reg = '0;
    makeup_reg = 24'd16384; chan_reg = 2'd1;
    rel_env = '0; att_env = '0; gain_st = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, zero frame, full-scale extremes, single channel ignores ch1.
    f = '{16'sd0, 16'sd0};             frame_q.push_back(f);
    f = '{16'sh7fff, 16'sh7fff};       frame_q.push_back(f);
    f = '{16'sh8000, 16'sh8000};       frame_q.push_back(f);
    f = '{16'sd1, -16'sd1};            frame_q.push_back(f);
    f = '{-16'sd1, 16'sh5555};         frame_q.push_back(f);
    drain();

    // Two channels, compressing threshold, opposite polarity sums.
    write_reg(REG_CHANNELS, 24'd2);
    write_reg(REG_THRESHOLD, 24'd16384);
    write_reg(REG_RATIO, 24'd16384);
    write_reg(REG_MAKEUP, 24'd65536);
    f = '{16'sh7fff, 16'sh7fff};       frame_q.push_back(f);
    f = '{16'sh8000, 16'sh8000};       frame_q.push_back(f);
    f = '{16'sh7fff, 16'sh8000};       frame_q.push_back(f);
    f = '{16'shaaaa, 16'sh5555};       frame_q.push_back(f);
    f = '{16'sd0, 16'sd0};             frame_q.push_back(f);
    drain();

    // Out-of-range settings: threshold/ratio above one, channel count 0 and 3,
    // zero threshold and ratio, huge makeup.
    write_reg(REG_THRESHOLD, 24'h1ffff);
    write_reg(REG_RATIO, 24'h1ffff);
    write_reg(REG_CHANNELS, 24'd3);
    write_reg(REG_MAKEUP, 24'hffffff);
    f = '{16'sh1234, 16'shedcb};       frame_q.push_back(f);
    f = '{16'sh8000, 16'sd100};        frame_q.push_back(f);
    drain();
    write_reg(REG_CHANNELS, 24'd0);
    write_reg(REG_THRESHOLD, 24'd0);
    write_reg(REG_RATIO, 24'd0);
    write_reg(REG_MAKEUP, 24'd16384000);
    f = '{16'sh4000, 16'sh7fff};       frame_q.push_back(f);
    f = '{16'sh8000, 16'sh8000};       frame_q.push_back(f);
    f = '{16'sd0, 16'sd0};             frame_q.push_back(f);
    drain();

    // Random phases across several settings, extremes of each pole included.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_THRESHOLD, (ph == 0) ? 24'd0 : (ph == 1) ? 24'h1ffff
                                 : 24'($urandom_range(0, 65536)));
      write_reg(REG_RATIO, (ph == 2) ? 24'd0 : (ph == 3) ? 24'h1ffff
                             : 24'($urandom_range(0, 65536)));
      write_reg(REG_ATTACK, (ph == 1) ? 24'd65535 : (ph == 0) ? 24'd0
                              : 24'($urandom_range(0, 65535)));
      write_reg(REG_RELEASE, (ph == 2) ? 24'd65535 : (ph == 3) ? 24'd0
                               : 24'($urandom_range(0, 65535)));
      write_reg(REG_KNEE, (ph == 3) ? 24'd65535 : (ph == 4) ? 24'd0
                            : 24'($urandom_range(0, 65535)));
      write_reg(REG_MAKEUP, (ph == 5) ? 24'd0 : (ph == 6) ? 24'hffffff
                              : 24'($urandom_range(16384, 262144)));
      write_reg(REG_CHANNELS, 24'($urandom_range(0, 3)));
      push_random(135);
      drain();
    end

    $display("Sent %0d frames over 12 register settings, %0d result words checked.",
             frames_sent, words_seen);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("peak_compressor verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expect_q.size());
      $display("peak_compressor verification failed");
    end
    $finish;
  end

endmodule
